// ===== sv/nbc_pkg.sv =====
// ----------------------------------------------------------------------------
// nbc_pkg
// shared constants, request codes and control structs of the naive bayes
// count classifier
// ----------------------------------------------------------------------------
package nbc_pkg;

  localparam int NUM_ATTRS_DEF  = 4;
  localparam int NUM_VALUES_DEF = 8;
  localparam int MAX_ROWS_DEF   = 1024;

  // fixed field widths of the channels
  localparam int REQ_W    = 2;
  localparam int CODE_W   = 3;
  localparam int CLS_W    = 2;
  localparam int ROWS_W   = 11;
  localparam int IN_ATTRS = 4;

  // limb width of the serial wide multiplier
  localparam int LIMB_W = 32;

  localparam logic [REQ_W-1:0] REQ_TRAIN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CLS_W-1:0] CLS_NO  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_YES = 2'd1;

  typedef struct packed {
    logic             train;
    logic             clr;
    logic             load;
    logic [CLS_W-1:0] cls;
  } lane_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
    logic first;
  } mul_ctl_t;

endpackage

// ===== sv/nbc_lane.sv =====
// ----------------------------------------------------------------------------
// nbc_lane
// one feature: joint counts per value and class, seen bitmap, and the four
// query factors of this feature
// ----------------------------------------------------------------------------
module nbc_lane #(
  parameter int NUM_VALUES = nbc_pkg::NUM_VALUES_DEF,
  parameter int CW         = 11,
  parameter int FW         = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  nbc_pkg::lane_ctl_t        ctl,
  input  logic [nbc_pkg::CODE_W-1:0] code,
  input  logic [CW-1:0]             rows_yes,
  input  logic [CW-1:0]             rows_no,
  output logic [FW-1:0]             fy_joint,
  output logic [FW-1:0]             fy_denom,
  output logic [FW-1:0]             fn_joint,
  output logic [FW-1:0]             fn_denom
);

  localparam int VW = $clog2(NUM_VALUES);
  localparam int UW = $clog2(NUM_VALUES + 1);

  logic [NUM_VALUES-1:0] seen_r;
  logic [CW-1:0]         jy_r [NUM_VALUES];
  logic [CW-1:0]         jn_r [NUM_VALUES];
  logic [FW-1:0]         fy_joint_r, fy_denom_r, fn_joint_r, fn_denom_r;

  logic          in_range;
  logic [VW-1:0] idx;
  logic [UW-1:0] ucount;
  logic [CW-1:0] jy_rd, jn_rd;

  assign in_range = 32'(code) < 32'(NUM_VALUES);
  assign idx      = VW'(code);
  assign jy_rd    = in_range ? jy_r[idx] : '0;
  assign jn_rd    = in_range ? jn_r[idx] : '0;

  // distinct values seen for this feature
  always_comb begin
    ucount = '0;
    for (int v = 0; v < NUM_VALUES; v++) begin
      ucount = ucount + UW'(seen_r[v]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      seen_r <= '0;
      for (int v = 0; v < NUM_VALUES; v++) begin
        jy_r[v] <= '0;
        jn_r[v] <= '0;
      end
    end else if (ctl.train && in_range) begin
      seen_r[idx] <= 1'b1;
      if (ctl.cls == nbc_pkg::CLS_NO) begin
        jn_r[idx] <= jn_r[idx] + CW'(1);
      end else if (ctl.cls == nbc_pkg::CLS_YES) begin
        jy_r[idx] <= jy_r[idx] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      fy_joint_r <= FW'(jy_rd) + FW'(1);
      fn_joint_r <= FW'(jn_rd) + FW'(1);
      fy_denom_r <= FW'(rows_no) + FW'(ucount);
      fn_denom_r <= FW'(rows_yes) + FW'(ucount);
    end
  end

  assign fy_joint = fy_joint_r;
  assign fy_denom = fy_denom_r;
  assign fn_joint = fn_joint_r;
  assign fn_denom = fn_denom_r;

endmodule

// ===== sv/nbc_mulacc.sv =====
// ----------------------------------------------------------------------------
// nbc_mulacc
// wide product accumulator, multiplied by one narrow factor a limb per cycle
// ----------------------------------------------------------------------------
module nbc_mulacc #(
  parameter int CW = 11,
  parameter int FW = 12,
  parameter int NL = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nbc_pkg::mul_ctl_t             ctl,
  input  logic [CW-1:0]                 init,
  input  logic [FW-1:0]                 factor,
  output logic [NL*nbc_pkg::LIMB_W-1:0] acc
);

  localparam int LW = nbc_pkg::LIMB_W;

  logic [LW-1:0]    limb_r [NL];
  logic [FW-1:0]    carry_r;
  logic [LW+FW-1:0] prod;
  logic [FW-1:0]    carry_in;

  // carry restarts with each new factor
  assign carry_in = ctl.first ? '0 : carry_r;
  assign prod     = (LW+FW)'(limb_r[0]) * (LW+FW)'(factor) + (LW+FW)'(carry_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else if (ctl.start) begin
      limb_r[0] <= LW'(init);
      for (int k = 1; k < NL; k++) begin
        limb_r[k] <= '0;
      end
      carry_r <= '0;
    end else if (ctl.step) begin
      // rotate: low limb out, new limb in at the top
      for (int k = 0; k < NL - 1; k++) begin
        limb_r[k] <= limb_r[k+1];
      end
      limb_r[NL-1] <= prod[LW-1:0];
      carry_r      <= prod[LW+FW-1:LW];
    end
  end

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      acc[k*LW +: LW] = limb_r[k];
    end
  end

endmodule

// ===== sv/naive_bayes_count_classifier.sv =====
// ----------------------------------------------------------------------------
// naive_bayes_count_classifier
// categorical naive bayes with add-one smoothing: train, query, clear
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------
//  in_     | input     | in_valid/in_stall| req_type, attr0..3_code, row_class
//  out_    | output    | out_valid/out_stall | predict_yes, row_accepted, rows_held
//
//  train and clear transactions update the stores at acceptance; the result
//  is posted from the wait state once the output register is free
//  a query runs the multiply state, then the compare and wait states; the
//  serial wide multiplier walks NL 32-bit limbs per factor
//  synchronous active-low reset clears every count and the seen bitmaps
//  one transaction is worked at a time; the next one is taken once the
//  previous result has moved into the output register, even if that
//  register is still stalled
//
module naive_bayes_count_classifier #(
  parameter int NUM_ATTRS  = nbc_pkg::NUM_ATTRS_DEF,
  parameter int NUM_VALUES = nbc_pkg::NUM_VALUES_DEF,
  parameter int MAX_ROWS   = nbc_pkg::MAX_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [nbc_pkg::REQ_W-1:0]    in_req_type,
  input  logic [nbc_pkg::CODE_W-1:0]   in_attr0_code,
  input  logic [nbc_pkg::CODE_W-1:0]   in_attr1_code,
  input  logic [nbc_pkg::CODE_W-1:0]   in_attr2_code,
  input  logic [nbc_pkg::CODE_W-1:0]   in_attr3_code,
  input  logic [nbc_pkg::CLS_W-1:0]    in_row_class,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_predict_yes,
  output logic                         out_row_accepted,
  output logic [nbc_pkg::ROWS_W-1:0]   out_rows_held
);

  // count width, factor width, product width and limb count
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int FW  = CW + 1;
  localparam int AW  = CW + 2 * NUM_ATTRS * FW;
  localparam int LW  = nbc_pkg::LIMB_W;
  localparam int NL  = (AW + LW - 1) / LW;
  localparam int LCW = (NL > 1) ? $clog2(NL) : 1;
  localparam int LIW = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_CMP,
    S_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // global counts
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] cy_r, cy_nxt;
  logic [CW-1:0] cn_r, cn_nxt;

  // sequencer for the multiply pass
  logic [LCW-1:0] lc_r, lc_nxt;
  logic [LIW-1:0] lane_r, lane_nxt;
  logic           part_r, part_nxt;

  // pending result and output register
  logic                       pend_yes_r, pend_yes_nxt;
  logic                       pend_acc_r, pend_acc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_yes_r, out_yes_nxt;
  logic                       out_acc_r, out_acc_nxt;
  logic [nbc_pkg::ROWS_W-1:0] out_rows_r, out_rows_nxt;

  logic in_take, out_free, full, do_train;
  logic [nbc_pkg::CODE_W-1:0] in_code [nbc_pkg::IN_ATTRS];

  nbc_pkg::lane_ctl_t lane_ctl;
  nbc_pkg::mul_ctl_t  mul_ctl;

  logic [FW-1:0] fy_joint [NUM_ATTRS];
  logic [FW-1:0] fy_denom [NUM_ATTRS];
  logic [FW-1:0] fn_joint [NUM_ATTRS];
  logic [FW-1:0] fn_denom [NUM_ATTRS];
  logic [FW-1:0] yes_factor, no_factor;
  logic [NL*LW-1:0] yes_acc, no_acc;

  assign in_code[0] = in_attr0_code;
  assign in_code[1] = in_attr1_code;
  assign in_code[2] = in_attr2_code;
  assign in_code[3] = in_attr3_code;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (total_r >= CW'(MAX_ROWS));
  assign do_train = in_take && (in_req_type == nbc_pkg::REQ_TRAIN) && !full;

  // lane control: stores update at acceptance, factors latched for a query
  always_comb begin
    lane_ctl.train = do_train;
    lane_ctl.clr   = in_take && (in_req_type == nbc_pkg::REQ_CLEAR);
    lane_ctl.load  = in_take && (in_req_type == nbc_pkg::REQ_QUERY);
    lane_ctl.cls   = in_row_class;
  end

  // one lane per feature; features past the fourth read code zero
  for (genvar g = 0; g < NUM_ATTRS; g++) begin : g_lane
    logic [nbc_pkg::CODE_W-1:0] lane_code;
    if (g < nbc_pkg::IN_ATTRS) begin : g_in
      assign lane_code = in_code[g];
    end else begin : g_zero
      assign lane_code = '0;
    end
    nbc_lane #(
      .NUM_VALUES (NUM_VALUES),
      .CW         (CW),
      .FW         (FW)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .code     (lane_code),
      .rows_yes (cy_r),
      .rows_no  (cn_r),
      .fy_joint (fy_joint[g]),
      .fy_denom (fy_denom[g]),
      .fn_joint (fn_joint[g]),
      .fn_denom (fn_denom[g])
    );
  end

  // merge: pick this pass's factor for each side
  assign yes_factor = part_r ? fy_denom[lane_r] : fy_joint[lane_r];
  assign no_factor  = part_r ? fn_denom[lane_r] : fn_joint[lane_r];

  always_comb begin
    mul_ctl.start = lane_ctl.load;
    mul_ctl.step  = (state_r == S_MUL);
    mul_ctl.first = (lc_r == '0);
  end

  // yes side starts from its prior count, no side from its own
  nbc_mulacc #(.CW(CW), .FW(FW), .NL(NL)) u_yes_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mul_ctl),
    .init   (cy_r),
    .factor (yes_factor),
    .acc    (yes_acc)
  );

  nbc_mulacc #(.CW(CW), .FW(FW), .NL(NL)) u_no_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mul_ctl),
    .init   (cn_r),
    .factor (no_factor),
    .acc    (no_acc)
  );

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    cy_nxt        = cy_r;
    cn_nxt        = cn_r;
    lc_nxt        = lc_r;
    lane_nxt      = lane_r;
    part_nxt      = part_r;
    pend_yes_nxt  = pend_yes_r;
    pend_acc_nxt  = pend_acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_yes_nxt   = out_yes_r;
    out_acc_nxt   = out_acc_r;
    out_rows_nxt  = out_rows_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          pend_yes_nxt = 1'b0;
          pend_acc_nxt = 1'b0;
          unique case (in_req_type)
            nbc_pkg::REQ_TRAIN: begin
              state_nxt = S_WAIT;
              if (!full) begin
                pend_acc_nxt = 1'b1;
                total_nxt    = total_r + CW'(1);
                if (in_row_class == nbc_pkg::CLS_NO) begin
                  cn_nxt = cn_r + CW'(1);
                end else if (in_row_class == nbc_pkg::CLS_YES) begin
                  cy_nxt = cy_r + CW'(1);
                end
              end
            end
            nbc_pkg::REQ_QUERY: begin
              state_nxt = S_MUL;
              lc_nxt    = '0;
              lane_nxt  = '0;
              part_nxt  = 1'b0;
            end
            nbc_pkg::REQ_CLEAR: begin
              state_nxt = S_WAIT;
              total_nxt = '0;
              cy_nxt    = '0;
              cn_nxt    = '0;
            end
            default: begin
              state_nxt = S_WAIT;
            end
          endcase
        end
      end
      S_MUL: begin
        if (lc_r == LCW'(NL - 1)) begin
          lc_nxt = '0;
          if (part_r) begin
            part_nxt = 1'b0;
            if (lane_r == LIW'(NUM_ATTRS - 1)) begin
              state_nxt = S_CMP;
            end else begin
              lane_nxt = lane_r + LIW'(1);
            end
          end else begin
            part_nxt = 1'b1;
          end
        end else begin
          lc_nxt = lc_r + LCW'(1);
        end
      end
      S_CMP: begin
        // empty yes class loses, empty no class loses, else strict compare
        priority if (cy_r == '0) begin
          pend_yes_nxt = 1'b0;
        end else if (cn_r == '0) begin
          pend_yes_nxt = 1'b1;
        end else begin
          pend_yes_nxt = (yes_acc > no_acc);
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_yes_nxt   = pend_yes_r;
          out_acc_nxt   = pend_acc_r;
          out_rows_nxt  = nbc_pkg::ROWS_W'(total_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      cy_r        <= '0;
      cn_r        <= '0;
      lc_r        <= '0;
      lane_r      <= '0;
      part_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      cy_r        <= cy_nxt;
      cn_r        <= cn_nxt;
      lc_r        <= lc_nxt;
      lane_r      <= lane_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_yes_r <= pend_yes_nxt;
    pend_acc_r <= pend_acc_nxt;
    out_yes_r  <= out_yes_nxt;
    out_acc_r  <= out_acc_nxt;
    out_rows_r <= out_rows_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_predict_yes  = out_yes_r;
  assign out_row_accepted = out_acc_r;
  assign out_rows_held    = out_rows_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives train, query, clear and unused transactions into the naive bayes
// classifier, predicts each result with an exact integer score model and
// checks every result field in order, under varying idle and stall rates
// ----------------------------------------------------------------------------
module testbench;

  localparam int NA = nbc_pkg::NUM_ATTRS_DEF;
  localparam int NV = nbc_pkg::NUM_VALUES_DEF;
  localparam int MAXR = nbc_pkg::MAX_ROWS_DEF;
  localparam int REQ_W = nbc_pkg::REQ_W;
  localparam int CODE_W = nbc_pkg::CODE_W;
  localparam int CLS_W = nbc_pkg::CLS_W;
  localparam int ROWS_W = nbc_pkg::ROWS_W;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [CLS_W-1:0] CLS_NEITHER = 2'd2;

  typedef struct {
    bit              yes;
    bit              acc;
    bit [ROWS_W-1:0] rows;
  } nb_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [CODE_W-1:0] in_attr0_code = '0, in_attr1_code = '0;
  logic [CODE_W-1:0] in_attr2_code = '0, in_attr3_code = '0;
  logic [CLS_W-1:0] in_row_class = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_predict_yes, out_row_accepted;
  logic [ROWS_W-1:0] out_rows_held;

  // shadow counts of the classifier
  int unsigned row_total;
  int unsigned cls_rows[2];
  int unsigned joint[NA*NV*2];
  bit seen[NA*NV];

  nb_result_t pending_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  naive_bayes_count_classifier u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_attr0_code(in_attr0_code), .in_attr1_code(in_attr1_code),
    .in_attr2_code(in_attr2_code), .in_attr3_code(in_attr3_code),
    .in_row_class(in_row_class),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_predict_yes(out_predict_yes), .out_row_accepted(out_row_accepted),
    .out_rows_held(out_rows_held)
  );

  always #6 clk = ~clk;

  // receiver stalls at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [CODE_W-1:0] rand_code(int unsigned lim);
    return CODE_W'($urandom_range(lim));
  endfunction

  function automatic logic [CLS_W-1:0] rand_cls();
    return CLS_W'($urandom_range(3));
  endfunction

  function automatic void clear_counts();
    row_total = 0;
    cls_rows[0] = 0;
    cls_rows[1] = 0;
    foreach (joint[i]) joint[i] = 0;
    foreach (seen[i]) seen[i] = 0;
  endfunction

  // exact compare of prior times smoothed likelihoods, common total cancels
  function automatic bit score_yes_wins(logic [CODE_W-1:0] codes[NA]);
    logic [127:0] yes_score, no_score;
    int unsigned cy, cn, distinct, jy, jn, base;
    cy = cls_rows[1];
    cn = cls_rows[0];
    if (cy == 0) return 1'b0;
    if (cn == 0) return 1'b1;
    yes_score = cy;
    no_score = cn;
    for (int a = 0; a < NA; a++) begin
      distinct = 0;
      for (int v = 0; v < NV; v++) distinct += seen[a*NV+v];
      base = (a*NV + codes[a]) * 2;
      jn = joint[base];
      jy = joint[base+1];
      yes_score = yes_score * (jy + 1) * (cn + distinct);
      no_score = no_score * (jn + 1) * (cy + distinct);
    end
    return yes_score > no_score;
  endfunction

  function automatic nb_result_t classify_step(logic [REQ_W-1:0] req,
                                               logic [CODE_W-1:0] codes[NA],
                                               logic [CLS_W-1:0] cls);
    nb_result_t r;
    r.yes = 0;
    r.acc = 0;
    case (req)
      nbc_pkg::REQ_TRAIN: begin
        if (row_total < MAXR) begin
          r.acc = 1;
          row_total++;
          if (cls < 2) cls_rows[cls]++;
          for (int a = 0; a < NA; a++) begin
            seen[a*NV+codes[a]] = 1;
            if (cls < 2) joint[(a*NV+codes[a])*2+cls]++;
          end
        end
      end
      nbc_pkg::REQ_QUERY: r.yes = score_yes_wins(codes);
      nbc_pkg::REQ_CLEAR: clear_counts();
      default: ;
    endcase
    r.rows = row_total[ROWS_W-1:0];
    return r;
  endfunction

  // one transaction; valid stays high into the next call unless it idles
  task automatic send_item(logic [REQ_W-1:0] req, logic [CODE_W-1:0] c0,
                           logic [CODE_W-1:0] c1, logic [CODE_W-1:0] c2,
                           logic [CODE_W-1:0] c3, logic [CLS_W-1:0] cls);
    logic [CODE_W-1:0] codes[NA];
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_attr0_code <= c0;
    in_attr1_code <= c1;
    in_attr2_code <= c2;
    in_attr3_code <= c3;
    in_row_class <= cls;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    codes = '{c0, c1, c2, c3};
    pending_results.insert(pending_results.size(), classify_step(req, codes, cls));
  endtask

  task automatic send_rand_row(logic [REQ_W-1:0] req, logic [CLS_W-1:0] cls);
    send_item(req, rand_code(7), rand_code(7), rand_code(7), rand_code(7), cls);
  endtask

  // stop sending and wait for every result, then idle on
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    nb_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result yes=%0d acc=%0d rows=%0d", $time,
                 out_predict_yes, out_row_accepted, out_rows_held);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_predict_yes !== exp_r.yes) begin
          $display("%0t predict_yes expected %0d actual %0d", $time,
                   exp_r.yes, out_predict_yes);
          errors++;
        end
        if (out_row_accepted !== exp_r.acc) begin
          $display("%0t row_accepted expected %0d actual %0d", $time,
                   exp_r.acc, out_row_accepted);
          errors++;
        end
        if (out_rows_held !== exp_r.rows) begin
          $display("%0t rows_held expected %0d actual %0d", $time,
                   exp_r.rows, out_rows_held);
          errors++;
        end
      end
    end
  end

  // empty store, unused request type, empty classes
  task automatic test_empty_classes();
    send_item(nbc_pkg::REQ_QUERY, 0, 0, 0, 0, nbc_pkg::CLS_NO);
    send_item(REQ_UNUSED, 7, 7, 7, 7, 2'd3);
    send_item(nbc_pkg::REQ_TRAIN, 7, 7, 7, 7, nbc_pkg::CLS_YES);
    send_item(nbc_pkg::REQ_QUERY, 7, 7, 7, 7, nbc_pkg::CLS_NO);
    send_item(nbc_pkg::REQ_QUERY, 0, 0, 0, 0, nbc_pkg::CLS_NO);
    send_item(nbc_pkg::REQ_CLEAR, 0, 0, 0, 0, nbc_pkg::CLS_NO);
    send_item(nbc_pkg::REQ_TRAIN, 5, 2, 1, 6, nbc_pkg::CLS_NO);
    send_item(nbc_pkg::REQ_QUERY, 5, 2, 1, 6, nbc_pkg::CLS_NO);
  endtask

  // neither class rows, ties and extreme codes
  task automatic test_neither_and_ties();
    send_item(nbc_pkg::REQ_CLEAR, 7, 7, 7, 7, 2'd3);
    send_item(nbc_pkg::REQ_TRAIN, 0, 7, 0, 7, CLS_NEITHER);
    send_item(nbc_pkg::REQ_TRAIN, 7, 0, 7, 0, 2'd3);
    send_item(nbc_pkg::REQ_TRAIN, 3, 3, 3, 3, nbc_pkg::CLS_YES);
    send_item(nbc_pkg::REQ_TRAIN, 3, 3, 3, 3, nbc_pkg::CLS_NO);
    send_item(nbc_pkg::REQ_QUERY, 3, 3, 3, 3, nbc_pkg::CLS_NO);
    send_item(nbc_pkg::REQ_TRAIN, 4, 4, 4, 4, nbc_pkg::CLS_YES);
    send_item(nbc_pkg::REQ_QUERY, 4, 4, 4, 4, nbc_pkg::CLS_NO);
    send_item(nbc_pkg::REQ_QUERY, 0, 7, 0, 7, nbc_pkg::CLS_YES);
    send_item(REQ_UNUSED, 0, 0, 0, 0, nbc_pkg::CLS_YES);
    send_item(nbc_pkg::REQ_QUERY, 7, 7, 7, 7, CLS_NEITHER);
  endtask

  // fill the table up to the row limit, then overfill
  task automatic test_table_full();
    send_item(nbc_pkg::REQ_CLEAR, 0, 0, 0, 0, nbc_pkg::CLS_NO);
    while (row_total < MAXR)
      send_rand_row(nbc_pkg::REQ_TRAIN, rand_cls());
    repeat (3) send_rand_row(nbc_pkg::REQ_TRAIN, rand_cls());
    repeat (3) send_rand_row(nbc_pkg::REQ_QUERY, nbc_pkg::CLS_NO);
    // pause until the block has caught up
    drain();
    send_item(nbc_pkg::REQ_CLEAR, 0, 0, 0, 0, nbc_pkg::CLS_NO);
  endtask

  // mostly train and query with random content, some clears and noise
  task automatic test_random_traffic(int n);
    int pick;
    logic [CODE_W-1:0] lim;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      lim = ($urandom_range(1) != 0) ? 3'd7 : 3'd2;
      if (pick < 55)
        send_item(nbc_pkg::REQ_TRAIN, rand_code(lim), rand_code(lim),
                  rand_code(lim), rand_code(lim), rand_cls());
      else if (pick < 92)
        send_item(nbc_pkg::REQ_QUERY, rand_code(lim), rand_code(lim),
                  rand_code(lim), rand_code(lim), rand_cls());
      else if (pick < 95)
        send_rand_row(nbc_pkg::REQ_CLEAR, rand_cls());
      else
        send_rand_row(REQ_UNUSED, rand_cls());
    end
  endtask

  initial begin
    clear_counts();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 38;
    recv_stall_pct = 57;
    test_empty_classes();
    test_neither_and_ties();
    test_random_traffic(40);
    send_idle_pct = 57;
    recv_stall_pct = 38;
    test_random_traffic(40);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_table_full();
    test_random_traffic(20);
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/nbc_pkg.sv
sv/nbc_lane.sv
sv/nbc_mulacc.sv
sv/naive_bayes_count_classifier.sv
bench/testbench.sv
